/* rtl/acl_pkg.sv */
// Shared types, widths and constants for the acceleration level classifier.
`timescale 1ns / 1ps

package acl_pkg;

  localparam int FRACTION_BITS = 14;
  localparam int AXIS_W        = 16;
  localparam int OUT_W         = 20;
  localparam int LEVEL_W       = 3;
  localparam int SQ_W          = 2 * AXIS_W;
  localparam int SUM_W         = 32;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int ROOT_STEPS    = ROOT_W;
  localparam int LIMIT_W       = 16;
  localparam int NUM_LIMITS    = 4;
  localparam int FACTOR_W      = 20;
  localparam int Q16_SHIFT     = 16;
  localparam int NUM_AXES      = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 20;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 88;

  localparam int QUARTER_G = 1 << (FRACTION_BITS - 2);
  localparam logic [LIMIT_W-1:0]  ZERO_LIMIT_RST   = LIMIT_W'(1 * QUARTER_G);
  localparam logic [LIMIT_W-1:0]  LOW_LIMIT_RST    = LIMIT_W'(3 * QUARTER_G);
  localparam logic [LIMIT_W-1:0]  NORMAL_LIMIT_RST = LIMIT_W'(5 * QUARTER_G);
  localparam logic [LIMIT_W-1:0]  HIGH_LIMIT_RST   = LIMIT_W'(7 * QUARTER_G);
  localparam logic [FACTOR_W-1:0] METRES_PER_G_RST = FACTOR_W'(642689);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_G = 3'd4;

  // limit slots
  localparam int LIM_ZERO   = 0;
  localparam int LIM_LOW    = 1;
  localparam int LIM_NORMAL = 2;
  localparam int LIM_HIGH   = 3;

  // level codes, quietest first
  localparam logic [LEVEL_W-1:0] LVL_REST     = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_LIGHT    = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_MODERATE = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_HEAVY    = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_EXTREME  = 3'd4;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TOGGLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_SUM,
    ST_CLASS,
    ST_ROOT,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
  } lane_ctrl_t;

  typedef struct packed {
    logic sum_en;
    logic class_en;
  } merge_ctrl_t;

endpackage

/* rtl/acl_lane.sv */
// One axis lane: holds the stored axis, forms its square and its scaled value.
`timescale 1ns / 1ps

module acl_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  acl_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [acl_pkg::AXIS_W-1:0]   raw,
  input  logic [acl_pkg::FACTOR_W-1:0]        factor,
  output logic signed [acl_pkg::AXIS_W-1:0]   stored,
  output logic [acl_pkg::SQ_W-1:0]            square,
  output logic signed [acl_pkg::OUT_W-1:0]    scaled
);

  localparam int PROD_W = acl_pkg::AXIS_W + acl_pkg::FACTOR_W + 1;

  logic signed [acl_pkg::SQ_W-1:0]       sq_full;
  logic signed [acl_pkg::FACTOR_W:0]     factor_s;
  logic signed [PROD_W-1:0]              prod;

  assign sq_full  = stored * stored;
  assign factor_s = $signed({1'b0, factor});
  assign prod     = PROD_W'(stored) * PROD_W'(factor_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
    end else if (ctrl.load) begin
      stored <= raw;
    end
  end

  // floor(stored * factor / 2^16) is an arithmetic shift
  always_ff @(posedge clk) begin
    if (ctrl.calc) begin
      square <= unsigned'(sq_full);
      scaled <= prod[acl_pkg::Q16_SHIFT +: acl_pkg::OUT_W];
    end
  end

endmodule

/* rtl/acl_merge.sv */
// Merge stage: sums the lane squares and classifies the level against the limits.
`timescale 1ns / 1ps

module acl_merge (
  input  logic                                                   clk,
  input  acl_pkg::merge_ctrl_t                                   ctrl,
  input  logic [acl_pkg::NUM_AXES-1:0][acl_pkg::SQ_W-1:0]        squares,
  input  logic [acl_pkg::NUM_LIMITS-1:0][acl_pkg::LIMIT_W-1:0]   limits,
  output logic [acl_pkg::SUM_W-1:0]                              sum,
  output logic [acl_pkg::LEVEL_W-1:0]                            level
);

  logic [acl_pkg::NUM_LIMITS-1:0][2*acl_pkg::LIMIT_W-1:0] lim_sq;
  logic [acl_pkg::SUM_W-1:0]                              sum_next;
  logic [acl_pkg::LEVEL_W-1:0]                            level_next;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < acl_pkg::NUM_AXES; i++) begin
      sum_next = sum_next + acl_pkg::SUM_W'(squares[i]);
    end
  end

  // strict compares, highest limit first
  always_comb begin
    if (sum > lim_sq[acl_pkg::LIM_HIGH]) begin
      level_next = acl_pkg::LVL_EXTREME;
    end else if (sum > lim_sq[acl_pkg::LIM_NORMAL]) begin
      level_next = acl_pkg::LVL_HEAVY;
    end else if (sum > lim_sq[acl_pkg::LIM_LOW]) begin
      level_next = acl_pkg::LVL_MODERATE;
    end else if (sum > lim_sq[acl_pkg::LIM_ZERO]) begin
      level_next = acl_pkg::LVL_LIGHT;
    end else begin
      level_next = acl_pkg::LVL_REST;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum <= sum_next;
      for (int i = 0; i < acl_pkg::NUM_LIMITS; i++) begin
        lim_sq[i] <= limits[i] * limits[i];
      end
    end
    if (ctrl.class_en) begin
      level <= level_next;
    end
  end

endmodule

/* rtl/acl_isqrt.sv */
// Iterative floored integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module acl_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [acl_pkg::SUM_W-1:0]     radicand,
  output logic [acl_pkg::ROOT_W-1:0]    root,
  output logic                          done
);

  localparam int CNT_W = $clog2(acl_pkg::ROOT_STEPS);
  localparam int REM_W = acl_pkg::ROOT_W + 2;
  localparam int TRY_W = REM_W + 2;

  logic [acl_pkg::SUM_W-1:0] rad;
  logic [REM_W-1:0]          rem;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic [TRY_W-1:0]          rem_shift;
  logic [TRY_W-1:0]          trial;
  logic                      fits;

  assign rem_shift = {rem, rad[acl_pkg::SUM_W-1 -: 2]};
  assign trial     = TRY_W'({root, 2'b01});
  assign fits      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(acl_pkg::ROOT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[acl_pkg::SUM_W-3:0], 2'b00};
      rem  <= fits ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
      root <= {root[acl_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule

/* rtl/accel_magnitude_level_classifier.sv */
// Top level: three-axis acceleration magnitude and level classifier.
//
// Input stream s_*: one transaction carries either a new sample (s_tuser = 0,
// three signed 16-bit axes in s_tdata) or a unit toggle (s_tuser = 1, axes
// ignored, the stored sample is reported again in the flipped unit).
// Output stream m_*: one transaction per input transaction with the three
// axes, the floored magnitude and the level 0..4; m_tuser is 1 for g, 0 for
// metres per second squared.
// Three axis lanes square and scale the axes in parallel; the merge stage
// sums and classifies; the magnitude comes from a shared bit-serial square
// root that resolves one bit per cycle. One item is in work at a time;
// s_tready returns in the cycle after the result is loaded, so a new item
// is taken only once the last one is loaded. The result sits in an output
// register: while the receiver stalls the next item is still taken and
// worked on, and waits at its last stage only until the register frees.
// Reset (rst, synchronous): unit metres per second squared, stored sample
// zero, limits 0.25/0.75/1.25/1.75 g and the metres-per-g factor at their
// defaults. Write cfg_* only while the block is idle.
`timescale 1ns / 1ps

module accel_magnitude_level_classifier (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [acl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [acl_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [acl_pkg::IN_DATA_W-1:0]      s_tdata,   // x_raw, y_raw, z_raw
  input  logic                               s_tuser,   // kind
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [acl_pkg::OUT_DATA_W-1:0]     m_tdata,   // x_out, y_out, z_out, magnitude, level
  output logic                               m_tuser    // unit_is_g
);

  localparam int MAG_PROD_W = acl_pkg::ROOT_W + acl_pkg::FACTOR_W;
  localparam int PAD_W = acl_pkg::OUT_DATA_W - 4 * acl_pkg::OUT_W - acl_pkg::LEVEL_W;

  acl_pkg::state_t state, state_next;
  acl_pkg::lane_ctrl_t  lane_ctrl;
  acl_pkg::merge_ctrl_t merge_ctrl;

  logic [acl_pkg::NUM_LIMITS-1:0][acl_pkg::LIMIT_W-1:0] limits;
  logic [acl_pkg::FACTOR_W-1:0] metres_per_g;
  logic                         unit_flag;

  logic s_fire;
  logic out_free;
  logic root_start;
  logic out_load;

  logic signed [acl_pkg::AXIS_W-1:0]                 raw    [acl_pkg::NUM_AXES];
  logic signed [acl_pkg::AXIS_W-1:0]                 stored [acl_pkg::NUM_AXES];
  logic signed [acl_pkg::OUT_W-1:0]                  scaled [acl_pkg::NUM_AXES];
  logic [acl_pkg::NUM_AXES-1:0][acl_pkg::SQ_W-1:0]   squares;

  logic [acl_pkg::SUM_W-1:0]   sum;
  logic [acl_pkg::LEVEL_W-1:0] level;
  logic [acl_pkg::ROOT_W-1:0]  root;
  logic                        root_done;
  logic [MAG_PROD_W-1:0]       mag_prod;

  logic signed [acl_pkg::OUT_W-1:0] out_axis [acl_pkg::NUM_AXES];
  logic [acl_pkg::OUT_W-1:0]        out_mag;
  logic [acl_pkg::LEVEL_W-1:0]      out_level;
  logic                             out_unit;

  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits[acl_pkg::LIM_ZERO]   <= acl_pkg::ZERO_LIMIT_RST;
      limits[acl_pkg::LIM_LOW]    <= acl_pkg::LOW_LIMIT_RST;
      limits[acl_pkg::LIM_NORMAL] <= acl_pkg::NORMAL_LIMIT_RST;
      limits[acl_pkg::LIM_HIGH]   <= acl_pkg::HIGH_LIMIT_RST;
      metres_per_g                <= acl_pkg::METRES_PER_G_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acl_pkg::REG_ZERO_LIMIT:   limits[acl_pkg::LIM_ZERO]   <= cfg_data[acl_pkg::LIMIT_W-1:0];
        acl_pkg::REG_LOW_LIMIT:    limits[acl_pkg::LIM_LOW]    <= cfg_data[acl_pkg::LIMIT_W-1:0];
        acl_pkg::REG_NORMAL_LIMIT: limits[acl_pkg::LIM_NORMAL] <= cfg_data[acl_pkg::LIMIT_W-1:0];
        acl_pkg::REG_HIGH_LIMIT:   limits[acl_pkg::LIM_HIGH]   <= cfg_data[acl_pkg::LIMIT_W-1:0];
        acl_pkg::REG_METRES_PER_G: metres_per_g <= cfg_data[acl_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_flag <= 1'b0;
    end else if (s_fire && s_tuser == acl_pkg::KIND_TOGGLE) begin
      unit_flag <= !unit_flag;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      acl_pkg::ST_IDLE:  if (s_tvalid) state_next = acl_pkg::ST_LANE;
      acl_pkg::ST_LANE:  state_next = acl_pkg::ST_SUM;
      acl_pkg::ST_SUM:   state_next = acl_pkg::ST_CLASS;
      acl_pkg::ST_CLASS: state_next = acl_pkg::ST_ROOT;
      acl_pkg::ST_ROOT:  if (root_done) state_next = acl_pkg::ST_SCALE;
      acl_pkg::ST_SCALE: state_next = acl_pkg::ST_OUT;
      acl_pkg::ST_OUT:   if (out_free) state_next = acl_pkg::ST_IDLE;
      default:           state_next = acl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready            = 1'b0;
    lane_ctrl           = '0;
    merge_ctrl          = '0;
    root_start          = 1'b0;
    out_load            = 1'b0;
    unique case (state)
      acl_pkg::ST_IDLE: begin
        s_tready       = 1'b1;
        lane_ctrl.load = s_tvalid && s_tuser == acl_pkg::KIND_SAMPLE;
      end
      acl_pkg::ST_LANE:  lane_ctrl.calc = 1'b1;
      acl_pkg::ST_SUM:   merge_ctrl.sum_en = 1'b1;
      acl_pkg::ST_CLASS: begin
        merge_ctrl.class_en = 1'b1;
        root_start          = 1'b1;
      end
      acl_pkg::ST_ROOT:  ;
      acl_pkg::ST_SCALE: ;
      acl_pkg::ST_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  // lanes
  assign raw[0] = $signed(s_tdata[0 +: acl_pkg::AXIS_W]);
  assign raw[1] = $signed(s_tdata[acl_pkg::AXIS_W +: acl_pkg::AXIS_W]);
  assign raw[2] = $signed(s_tdata[2*acl_pkg::AXIS_W +: acl_pkg::AXIS_W]);

  for (genvar g = 0; g < acl_pkg::NUM_AXES; g++) begin : g_lane
    acl_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lane_ctrl),
      .raw    (raw[g]),
      .factor (metres_per_g),
      .stored (stored[g]),
      .square (squares[g]),
      .scaled (scaled[g])
    );
  end

  acl_merge u_merge (
    .clk     (clk),
    .ctrl    (merge_ctrl),
    .squares (squares),
    .limits  (limits),
    .sum     (sum),
    .level   (level)
  );

  acl_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sum),
    .root     (root),
    .done     (root_done)
  );

  // magnitude in metres: floor(root * factor / 2^16), always within 20 bits
  always_ff @(posedge clk) begin
    if (state == acl_pkg::ST_SCALE) begin
      mag_prod <= MAG_PROD_W'(root) * MAG_PROD_W'(metres_per_g);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < acl_pkg::NUM_AXES; i++) begin
        out_axis[i] <= unit_flag ? acl_pkg::OUT_W'(stored[i]) : scaled[i];
      end
      out_mag   <= unit_flag ? acl_pkg::OUT_W'(root)
                             : mag_prod[acl_pkg::Q16_SHIFT +: acl_pkg::OUT_W];
      out_level <= level;
      out_unit  <= unit_flag;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_level, out_mag,
                    out_axis[2], out_axis[1], out_axis[0]};
  assign m_tuser = out_unit;

`ifndef ASSERT_OFF
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (33'(root) * 33'(root) <= 33'(sum)) &&
                  ((33'(root) + 33'd1) * (33'(root) + 33'd1) > 33'(sum)))
    else $error("square root result is not the floor root of the sum");

  a_unit_on_accept: assert property (@(posedge clk) disable iff (rst)
    !s_fire |=> $stable(unit_flag))
    else $error("unit changed without an input transaction");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !$rose(m_tvalid))
    else $error("result raised right after an input transaction");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_level <= acl_pkg::LVL_EXTREME))
    else $error("level code out of range");
`endif

endmodule

/* verif/tb_accel_magnitude_level_classifier.sv */
// Self-checking testbench for the acceleration magnitude level classifier.
`timescale 1ns / 1ps

module tb_accel_magnitude_level_classifier;
  import acl_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic        kind;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } sample_item_t;

  typedef struct packed {
    logic        unit_is_g;
    logic [2:0]  level;
    logic [19:0] magnitude;
    logic [19:0] z_out;
    logic [19:0] y_out;
    logic [19:0] x_out;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ZERO_LIMIT;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = KIND_SAMPLE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  // model state and register copies
  logic [15:0]        lim_zero   = ZERO_LIMIT_RST;
  logic [15:0]        lim_low    = LOW_LIMIT_RST;
  logic [15:0]        lim_normal = NORMAL_LIMIT_RST;
  logic [15:0]        lim_high   = HIGH_LIMIT_RST;
  logic [19:0]        mps2_factor = METRES_PER_G_RST;
  logic               unit_g = 1'b0;
  logic signed [15:0] kept_x = '0;
  logic signed [15:0] kept_y = '0;
  logic signed [15:0] kept_z = '0;

  sample_item_t pending_samples[$];
  reading_t     expected_readings[$];
  sample_item_t tx_item;
  int unsigned  tx_gap = 0;
  bit           tx_burst = 1'b0;
  int unsigned  rx_wait = 0;
  bit           rx_burst = 1'b0;
  int           results_seen = 0;
  int           errors = 0;
  int           cycles = 0;

  accel_magnitude_level_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  function automatic logic [19:0] axis_out(input logic signed [15:0] a);
    longint scaled;
    if (unit_g) return {{4{a[15]}}, a};
    scaled = (longint'(a) * longint'({44'd0, mps2_factor})) >>> Q16_SHIFT;
    return scaled[19:0];
  endfunction

  function automatic reading_t predict_reading(input logic kind, input logic signed [15:0] xr,
                                               input logic signed [15:0] yr,
                                               input logic signed [15:0] zr);
    reading_t   r;
    logic [63:0] sum;
    logic [63:0] root;
    logic [63:0] trial;
    if (kind == KIND_TOGGLE) begin
      unit_g = ~unit_g;
    end else begin
      kept_x = xr;
      kept_y = yr;
      kept_z = zr;
    end
    sum = 64'(longint'(kept_x) * longint'(kept_x)) + 64'(longint'(kept_y) * longint'(kept_y))
        + 64'(longint'(kept_z) * longint'(kept_z));
    if (sum > 64'(lim_high) * 64'(lim_high)) r.level = LVL_EXTREME;
    else if (sum > 64'(lim_normal) * 64'(lim_normal)) r.level = LVL_HEAVY;
    else if (sum > 64'(lim_low) * 64'(lim_low)) r.level = LVL_MODERATE;
    else if (sum > 64'(lim_zero) * 64'(lim_zero)) r.level = LVL_LIGHT;
    else r.level = LVL_REST;
    root = '0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum) root = trial;
    end
    if (!unit_g) begin
      root = (root * 64'(mps2_factor)) >> Q16_SHIFT;
      if (root > 64'hF_FFFF) root = 64'hF_FFFF;
    end
    r.magnitude = root[19:0];
    r.x_out = axis_out(kept_x);
    r.y_out = axis_out(kept_y);
    r.z_out = axis_out(kept_z);
    r.unit_is_g = unit_g;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [19:0] want, input logic [19:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h/%b", $time, m_tdata, m_tuser);
      return;
    end
    want = expected_readings.pop_front();
    check_field("x_out", want.x_out, m_tdata[19:0]);
    check_field("y_out", want.y_out, m_tdata[39:20]);
    check_field("z_out", want.z_out, m_tdata[59:40]);
    check_field("magnitude", want.magnitude, m_tdata[79:60]);
    check_field("level", 20'(want.level), 20'(m_tdata[82:80]));
    check_field("unit_is_g", 20'(want.unit_is_g), 20'(m_tuser));
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_readings.push_back(predict_reading(s_tuser, s_tdata[15:0], s_tdata[31:16],
                                                    s_tdata[47:32]));
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          tx_item = pending_samples.pop_front();
          s_tdata <= {tx_item.z, tx_item.y, tx_item.x};
          s_tuser <= tx_item.kind;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 10);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_reading();
        results_seen++;
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        if (results_seen == HOLD_AT) rx_wait = HOLD_CYCLES;
        else rx_wait = rx_burst ? 0 : $urandom_range(0, 10);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic set_config(input logic [15:0] z, input logic [15:0] l, input logic [15:0] n,
                            input logic [15:0] h, input logic [19:0] f);
    cfg_write(REG_ZERO_LIMIT, {4'd0, z});
    cfg_write(REG_LOW_LIMIT, {4'd0, l});
    cfg_write(REG_NORMAL_LIMIT, {4'd0, n});
    cfg_write(REG_HIGH_LIMIT, {4'd0, h});
    cfg_write(REG_METRES_PER_G, f);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_zero = z;
    lim_low = l;
    lim_normal = n;
    lim_high = h;
    mps2_factor = f;
  endtask

  task automatic add_item(input logic kind, input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] z);
    sample_item_t it;
    it.kind = kind;
    it.x = x;
    it.y = y;
    it.z = z;
    pending_samples.push_back(it);
  endtask

  function automatic logic [15:0] rand_axis();
    int unsigned k;
    k = $urandom_range(0, 15);
    return 16'($urandom_range(0, (2 << k) - 1) - (1 << k));
  endfunction

  // single-axis value at or one away from one of the current limits
  function automatic logic [15:0] near_limit();
    int v;
    case ($urandom_range(0, 3))
      0: v = lim_zero;
      1: v = lim_low;
      2: v = lim_normal;
      default: v = lim_high;
    endcase
    v = v + int'($urandom_range(0, 2)) - 1;
    if (v < 0 || v > 32767) v = $urandom_range(0, 32767);
    if ($urandom_range(0, 1) == 1) v = -v;
    return 16'(v);
  endfunction

  task automatic add_random(input int count);
    logic kind;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 4) == 0) ? KIND_TOGGLE : KIND_SAMPLE;
      case ($urandom_range(0, 7))
        0, 1: add_item(kind, 16'($urandom), 16'($urandom), 16'($urandom));
        2: add_item(kind, near_limit(), 16'd0, 16'd0);
        default: add_item(kind, rand_axis(), rand_axis(), rand_axis());
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_config(ZERO_LIMIT_RST, LOW_LIMIT_RST, NORMAL_LIMIT_RST, HIGH_LIMIT_RST,
               METRES_PER_G_RST);

    // directed: reset state, axis extremes, rounding of negatives, unit toggles,
    // and each limit exactly met versus just exceeded
    add_item(KIND_TOGGLE, 16'($urandom), 16'($urandom), 16'($urandom));
    add_item(KIND_TOGGLE, 16'($urandom), 16'($urandom), 16'($urandom));
    add_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd0);
    add_item(KIND_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_item(KIND_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    add_item(KIND_SAMPLE, 16'h8000, 16'h7FFF, 16'h0001);
    add_item(KIND_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_item(KIND_TOGGLE, 16'hFFFF, 16'h0000, 16'h5555);
    add_item(KIND_SAMPLE, 16'h8000, 16'h0001, 16'hFFFF);
    add_item(KIND_TOGGLE, 16'hAAAA, 16'h0F0F, 16'hF0F0);
    add_item(KIND_SAMPLE, 16'd4096, 16'd0, 16'd0);
    add_item(KIND_SAMPLE, 16'd4097, 16'd0, 16'd0);
    add_item(KIND_SAMPLE, 16'd0, 16'd12288, 16'd0);
    add_item(KIND_SAMPLE, 16'd0, 16'd12289, 16'd0);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd20480);
    add_item(KIND_SAMPLE, 16'd0, 16'd0, -16'sd20481);
    add_item(KIND_SAMPLE, -16'sd28672, 16'd0, 16'd0);
    add_item(KIND_SAMPLE, 16'd28673, 16'd0, 16'd0);
    add_item(KIND_SAMPLE, 16'd0, -16'sd4097, 16'd0);
    wait_drained();

    // long receiver hold-off lands in this phase
    add_random(150);
    wait_drained();

    set_config(16'd0, 16'd0, 16'd0, 16'd0, 20'd0);
    add_random(60);
    wait_drained();

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hF_FFFF);
    add_random(60);
    wait_drained();

    // limits in reverse order
    set_config(HIGH_LIMIT_RST, NORMAL_LIMIT_RST, LOW_LIMIT_RST, ZERO_LIMIT_RST,
               20'($urandom));
    add_random(80);
    wait_drained();

    set_config(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
               16'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)),
               20'($urandom));
    add_random(150);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0) begin
      errors++;
      $display("%0t: missing results, expected %0d more, actual 0", $time,
               expected_readings.size());
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
